### rtl/core/kwm_pkg.sv
// ----------------------------------------------------------------------------
// kwm_pkg: shared types and constants of the k-way run merger
// Transaction payloads, command and register codes, head update bundle.
// ----------------------------------------------------------------------------
package kwm_pkg;

  localparam int MAX_LANES = 8;     // run_id is 3 bits wide
  localparam int RUN_ID_W  = 3;
  localparam int KEY_W     = 64;
  localparam int PAY_W     = 32;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 4;

  localparam logic [CFG_DAT_W-1:0] RUNS_IN_USE_RST = 4'd8;

  // command codes
  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_END    = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUNS_IN_USE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DESCENDING  = 1'b1;

  typedef struct packed {
    logic                command;
    logic [RUN_ID_W-1:0] run_id;
    logic [KEY_W-1:0]    sort_key;
    logic [PAY_W-1:0]    payload;
  } in_item_t;

  typedef struct packed {
    logic [KEY_W-1:0]    record_key;
    logic [PAY_W-1:0]    record_payload;
    logic [RUN_ID_W-1:0] from_run;
    logic                done_res;
  } out_item_t;

  // per-lane update masks, already qualified by the commit of an item
  typedef struct packed {
    logic [MAX_LANES-1:0] load;
    logic [MAX_LANES-1:0] finish;
    logic [MAX_LANES-1:0] take;
  } head_upd_t;

endpackage

### rtl/core/k_way_sorted_run_merge_core.sv
// ----------------------------------------------------------------------------
// k_way_sorted_run_merge_core: k-way merger of sorted runs
// Holds one head per run and emits the best head once all active runs are
// either filled or ended, then a done marker when every active run has ended.
// ----------------------------------------------------------------------------
// One input transaction is taken every cycle while the input is not stalled.
// Each transaction is registered; from the input register it updates the head
// store while a comparator tree over the (at most eight) register-held heads
// picks the winner, whose result is written to the output register. The input
// only stalls when a result must be written while the output register is
// still held. Heads are not cleared by reset, only valid and ended flags.
// A record emitted from run r must be followed by a refill or end of run r.
// ----------------------------------------------------------------------------
module k_way_sorted_run_merge_core #(
  parameter int RUNS         = 8,
  parameter int KEY_BITS     = 64,
  parameter int PAYLOAD_BITS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [kwm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [kwm_pkg::CFG_DAT_W-1:0]        cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  kwm_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output kwm_pkg::out_item_t                   out_data
);

  localparam int LANES = (RUNS < kwm_pkg::MAX_LANES) ? RUNS : kwm_pkg::MAX_LANES;
  localparam int KB    = KEY_BITS;
  localparam int PB    = (PAYLOAD_BITS < kwm_pkg::PAY_W) ? PAYLOAD_BITS : kwm_pkg::PAY_W;
  localparam int IW    = $clog2(LANES);

  // configuration
  logic [kwm_pkg::CFG_DAT_W-1:0] runs_in_use;
  logic                          descending;

  always_ff @(posedge clk) begin
    if (rst) begin
      runs_in_use <= kwm_pkg::RUNS_IN_USE_RST;
      descending  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        kwm_pkg::CFG_RUNS_IN_USE: runs_in_use <= cfg_data;
        kwm_pkg::CFG_DESCENDING:  descending  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic [kwm_pkg::CFG_DAT_W-1:0] n_act;
  logic [LANES-1:0]              act;

  always_comb begin
    if (runs_in_use == '0) begin
      n_act = kwm_pkg::CFG_DAT_W'(1);
    end else if (runs_in_use > kwm_pkg::CFG_DAT_W'(LANES)) begin
      n_act = kwm_pkg::CFG_DAT_W'(LANES);
    end else begin
      n_act = runs_in_use;
    end
    for (int i = 0; i < LANES; i++) begin
      act[i] = kwm_pkg::CFG_DAT_W'(i) < n_act;
    end
  end

  // input register
  logic              s1_valid;
  kwm_pkg::in_item_t s1_item;
  logic              fire;
  logic              emit;

  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item <= in_data;
    end
  end

  // head store
  kwm_pkg::head_upd_t upd;
  logic [KB-1:0]      head_key [LANES];
  logic [PB-1:0]      head_pay [LANES];
  logic [LANES-1:0]   hv;
  logic [LANES-1:0]   ended;

  kwm_heads #(
    .LANES (LANES),
    .KB    (KB),
    .PB    (PB)
  ) u_heads (
    .clk        (clk),
    .rst        (rst),
    .upd        (upd),
    .wr_key     (s1_item.sort_key[KB-1:0]),
    .wr_pay     (s1_item.payload[PB-1:0]),
    .head_key   (head_key),
    .head_pay   (head_pay),
    .head_valid (hv),
    .run_ended  (ended)
  );

  // state as seen after the registered item is applied
  logic [LANES-1:0] sel;
  logic [LANES-1:0] load_m;
  logic [LANES-1:0] fin_m;
  logic [LANES-1:0] hv_v;
  logic [LANES-1:0] ended_v;
  logic [KB-1:0]    key_v [LANES];
  logic [PB-1:0]    pay_v [LANES];
  logic             hit;
  logic             pending;
  logic             all_end;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sel[i]   = s1_item.run_id == kwm_pkg::RUN_ID_W'(i);
      key_v[i] = load_m[i] ? s1_item.sort_key[KB-1:0] : head_key[i];
      pay_v[i] = load_m[i] ? s1_item.payload[PB-1:0] : head_pay[i];
    end
  end

  // unknown, inactive, full and ended runs are ignored
  assign hit     = s1_valid && |(sel & act & ~hv & ~ended);
  assign load_m  = (hit && s1_item.command == kwm_pkg::CMD_RECORD) ? sel : '0;
  assign fin_m   = (hit && s1_item.command == kwm_pkg::CMD_END) ? sel : '0;
  assign hv_v    = hv | load_m;
  assign ended_v = ended | fin_m;
  assign pending = |(act & ~hv_v & ~ended_v);
  assign all_end = &(ended_v | ~act);

  logic          found;
  logic [IW-1:0] win;
  logic [KB-1:0] win_key;

  kwm_select #(
    .LANES (LANES),
    .KB    (KB),
    .IW    (IW)
  ) u_select (
    .desc    (descending),
    .valid   (act & hv_v),
    .keys    (key_v),
    .found   (found),
    .win     (win),
    .win_key (win_key)
  );

  // with no active run pending, no head means every active run has ended
  assign emit = hit && !pending;
  assign fire = s1_valid && (!emit || !out_valid || out_ready);

  logic [LANES-1:0] take_m;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      take_m[i] = emit && found && (win == IW'(i));
    end
    upd        = '0;
    upd.load   = kwm_pkg::MAX_LANES'(fire ? load_m : '0);
    upd.finish = kwm_pkg::MAX_LANES'(fire ? fin_m : '0);
    upd.take   = kwm_pkg::MAX_LANES'(fire ? take_m : '0);
  end

  // result register
  kwm_pkg::out_item_t res;

  always_comb begin
    res = '0;
    if (found) begin
      res.record_key     = kwm_pkg::KEY_W'(win_key);
      res.record_payload = kwm_pkg::PAY_W'(pay_v[win]);
      res.from_run       = kwm_pkg::RUN_ID_W'(win);
    end else begin
      res.done_res = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_data <= res;
    end
  end

  // checks
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(|(hv & ended)))
    else $error("run holds a head and is marked ended");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !fire |=> s1_valid && $stable(s1_item))
    else $error("registered item lost while stalled");

  a_winner_cleared: assert property (@(posedge clk) disable iff (rst)
    fire && emit && found |=> !hv[$past(win)])
    else $error("emitted head still marked valid");

  a_done_all_ended: assert property (@(posedge clk) disable iff (rst)
    fire && emit && !found |=> &(ended | ~act))
    else $error("done marker with an active run not ended");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    fire && emit |-> !out_valid || out_ready)
    else $error("result register overwritten before transaction");

endmodule

### rtl/core/kwm_heads.sv
// ----------------------------------------------------------------------------
// kwm_heads: head record store
// One key/payload register per run plus head-valid and run-ended flags.
// ----------------------------------------------------------------------------
module kwm_heads #(
  parameter int LANES = 8,
  parameter int KB    = 64,
  parameter int PB    = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  kwm_pkg::head_upd_t    upd,
  input  logic [KB-1:0]         wr_key,
  input  logic [PB-1:0]         wr_pay,
  output logic [KB-1:0]         head_key [LANES],
  output logic [PB-1:0]         head_pay [LANES],
  output logic [LANES-1:0]      head_valid,
  output logic [LANES-1:0]      run_ended
);

  always_ff @(posedge clk) begin
    for (int i = 0; i < LANES; i++) begin
      if (upd.load[i]) begin
        head_key[i] <= wr_key;
        head_pay[i] <= wr_pay;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= '0;
      run_ended  <= '0;
    end else begin
      // a head loaded and emitted by the same item ends up not valid
      head_valid <= (head_valid | upd.load[LANES-1:0]) & ~upd.take[LANES-1:0];
      run_ended  <= run_ended | upd.finish[LANES-1:0];
    end
  end

endmodule

### rtl/core/kwm_select.sv
// ----------------------------------------------------------------------------
// kwm_select: winner selection tree
// Binary comparator tree over the run heads; ties go to the lower run.
// ----------------------------------------------------------------------------
module kwm_select #(
  parameter int LANES = 8,
  parameter int KB    = 64,
  parameter int IW    = 3
) (
  input  logic              desc,
  input  logic [LANES-1:0]  valid,
  input  logic [KB-1:0]     keys [LANES],
  output logic              found,
  output logic [IW-1:0]     win,
  output logic [KB-1:0]     win_key
);

  localparam int P  = 1 << IW;
  localparam int NN = 2 * P - 1;

  wire          nv [NN];
  wire [KB-1:0] nk [NN];
  wire [IW-1:0] ni [NN];

  genvar g;
  generate
    for (g = 0; g < P; g++) begin : g_leaf
      if (g < LANES) begin : g_used
        assign nv[P-1+g] = valid[g];
        assign nk[P-1+g] = keys[g];
        assign ni[P-1+g] = IW'(g);
      end else begin : g_pad
        assign nv[P-1+g] = 1'b0;
        assign nk[P-1+g] = '0;
        assign ni[P-1+g] = '0;
      end
    end

    for (g = 0; g < P - 1; g++) begin : g_node
      logic pick_r;
      // right child only wins on a strictly better key
      assign pick_r = nv[2*g+2] && (!nv[2*g+1] ||
                      (desc ? (nk[2*g+2] > nk[2*g+1]) : (nk[2*g+2] < nk[2*g+1])));
      assign nv[g] = nv[2*g+1] || nv[2*g+2];
      assign nk[g] = pick_r ? nk[2*g+2] : nk[2*g+1];
      assign ni[g] = pick_r ? ni[2*g+2] : ni[2*g+1];
    end
  endgenerate

  assign found   = nv[0];
  assign win     = ni[0];
  assign win_key = nk[0];

endmodule

### bench/tb_k_way_sorted_run_merge_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_k_way_sorted_run_merge_core: self-checking bench for the k-way run merger
// Drives record and end-of-run transactions with random idling on both
// channels, predicts every emitted head and done marker from a private model
// of the head store, and compares each output transaction field by field.
// ----------------------------------------------------------------------------
module tb_k_way_sorted_run_merge_core;

  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT  = 1000000;

  // Holds the expected head store and the records it must emit, oldest first.
  class merge_order_board;
    logic [kwm_pkg::KEY_W-1:0] head_key[kwm_pkg::MAX_LANES];
    logic [kwm_pkg::PAY_W-1:0] head_pay[kwm_pkg::MAX_LANES];
    bit                        head_full[kwm_pkg::MAX_LANES];
    bit                        ended[kwm_pkg::MAX_LANES];
    int                        lanes;
    bit                        desc;
    kwm_pkg::out_item_t        due_records[$];
    int                        consumed;
    int                        errors;

    function new();
      for (int i = 0; i < kwm_pkg::MAX_LANES; i++) begin
        head_full[i] = 1'b0;
        ended[i]     = 1'b0;
      end
      lanes     = kwm_pkg::MAX_LANES;
      desc      = 1'b0;
      consumed  = 0;
      errors    = 0;
    endfunction

    function void set_config(logic [kwm_pkg::CFG_DAT_W-1:0] lanes_req, bit desc_req);
      if (lanes_req == 0) lanes = 1;
      else if (lanes_req > kwm_pkg::MAX_LANES) lanes = kwm_pkg::MAX_LANES;
      else lanes = int'(lanes_req);
      desc = desc_req;
    endfunction

    function bit is_open(int r);
      return r < lanes && !head_full[r] && !ended[r];
    endfunction

    function bit all_ended();
      for (int i = 0; i < kwm_pkg::MAX_LANES; i++)
        if (!ended[i]) return 1'b0;
      return 1'b1;
    endfunction

    // random run still waiting for a head, -1 when none
    function int pick_open_run();
      int open_runs[$];
      for (int i = 0; i < lanes; i++)
        if (is_open(i)) open_runs = {open_runs, i};
      if (open_runs.size() == 0) return -1;
      return open_runs[$urandom_range(0, open_runs.size() - 1)];
    endfunction

    function void absorb_item(kwm_pkg::in_item_t it);
      int                 r;
      int                 best;
      int                 i;
      kwm_pkg::out_item_t res;
      r = int'(it.run_id);
      if (r >= lanes || ended[r] || head_full[r]) return;
      consumed++;
      if (it.command == kwm_pkg::CMD_END) begin
        ended[r] = 1'b1;
      end else begin
        head_key[r]  = it.sort_key;
        head_pay[r]  = it.payload;
        head_full[r] = 1'b1;
      end
      best = -1;
      for (i = 0; i < lanes; i++) begin
        if (!head_full[i] && !ended[i]) return;
        if (head_full[i]) begin
          if (best < 0) best = i;
          else if (desc ? head_key[i] > head_key[best] : head_key[i] < head_key[best])
            best = i;
        end
      end
      if (best >= 0) begin
        res.record_key     = head_key[best];
        res.record_payload = head_pay[best];
        res.from_run       = best[kwm_pkg::RUN_ID_W-1:0];
        res.done_res       = 1'b0;
        head_full[best]    = 1'b0;
      end else begin
        res.record_key     = '0;
        res.record_payload = '0;
        res.from_run       = '0;
        res.done_res       = 1'b1;
      end
      due_records = {due_records, res};
    endfunction

    function void check_emitted(kwm_pkg::out_item_t got);
      kwm_pkg::out_item_t want;
      if (due_records.size() == 0) begin
        $display("%0t: unexpected output transaction key %h payload %h run %0d done %0b",
                 $time, got.record_key, got.record_payload, got.from_run, got.done_res);
        errors++;
        return;
      end
      want = due_records.pop_front();
      if (got.record_key !== want.record_key) begin
        $display("%0t: record_key expected %h got %h", $time, want.record_key, got.record_key);
        errors++;
      end
      if (got.record_payload !== want.record_payload) begin
        $display("%0t: record_payload expected %h got %h", $time, want.record_payload,
                 got.record_payload);
        errors++;
      end
      if (got.from_run !== want.from_run) begin
        $display("%0t: from_run expected %0d got %0d", $time, want.from_run, got.from_run);
        errors++;
      end
      if (got.done_res !== want.done_res) begin
        $display("%0t: done_res expected %0b got %0b", $time, want.done_res, got.done_res);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          cfg_we;
  logic [kwm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [kwm_pkg::CFG_DAT_W-1:0] cfg_data;
  logic                          in_valid;
  logic                          in_ready;
  kwm_pkg::in_item_t             in_data;
  logic                          out_valid;
  logic                          out_ready;
  kwm_pkg::out_item_t            out_data;

  merge_order_board book;
  int               ready_left;
  int               cycle_count;

  k_way_sorted_run_merge_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [kwm_pkg::KEY_W-1:0] rand_key();
    case ($urandom_range(0, 3))
      0: return {$urandom, $urandom};
      1: return kwm_pkg::KEY_W'($urandom_range(0, 7));
      2: return ~kwm_pkg::KEY_W'($urandom_range(0, 7));
      default: return kwm_pkg::KEY_W'($urandom_range(0, 3)) << 40;
    endcase
  endfunction

  function automatic kwm_pkg::in_item_t make_item(logic cmd, int r,
                                                  logic [kwm_pkg::KEY_W-1:0] key,
                                                  logic [kwm_pkg::PAY_W-1:0] pay);
    kwm_pkg::in_item_t it;
    it.command  = cmd;
    it.run_id   = r[kwm_pkg::RUN_ID_W-1:0];
    it.sort_key = key;
    it.payload  = pay;
    return it;
  endfunction

  // output side: ready high for a while, then a stall, mostly short
  always @(negedge clk) begin
    if (ready_left == 0) begin
      if (out_ready) begin
        out_ready  <= 1'b0;
        ready_left <= idle_len();
      end else begin
        out_ready  <= 1'b1;
        ready_left <= $urandom_range(1, 60);
      end
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) book.check_emitted(out_data);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("[k_way_sorted_run_merge_core] ERROR");
      $finish;
    end
  end

  // all tasks start and end just after a falling edge
  task automatic write_config(input logic [kwm_pkg::CFG_DAT_W-1:0] lanes_req,
                              input bit desc_req);
    cfg_we    <= 1'b1;
    cfg_index <= kwm_pkg::CFG_RUNS_IN_USE;
    cfg_data  <= lanes_req;
    @(negedge clk);
    cfg_index <= kwm_pkg::CFG_DESCENDING;
    cfg_data  <= {3'($urandom_range(0, 7)), desc_req};
    @(negedge clk);
    cfg_we <= 1'b0;
    book.set_config(lanes_req, desc_req);
  endtask

  task automatic idle_gap();
    int n;
    n = idle_len();
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic send_item(input kwm_pkg::in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.absorb_item(it);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (book.due_records.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic directed_part();
    // single active run (zero acts as one), inactive runs ignored
    write_config(4'd0, 1'b0);
    send_item(make_item(kwm_pkg::CMD_RECORD, 0, '0, '0));
    send_item(make_item(kwm_pkg::CMD_RECORD, 1, 64'd5, 32'd5));
    send_item(make_item(kwm_pkg::CMD_END, 4, '0, '0));
    send_item(make_item(kwm_pkg::CMD_RECORD, 0, '1, '1));
    send_item(make_item(kwm_pkg::CMD_RECORD, 0, 64'h8000_0000_0000_0000, 32'h8000_0000));
    settle();
    // oversized run count caps at eight, descending with three-way tie on the max key
    write_config(4'd15, 1'b1);
    send_item(make_item(kwm_pkg::CMD_RECORD, 3, '1, 32'd1));
    send_item(make_item(kwm_pkg::CMD_RECORD, 3, '0, 32'd9));
    send_item(make_item(kwm_pkg::CMD_END, 3, '0, '0));
    send_item(make_item(kwm_pkg::CMD_RECORD, 1, '1, 32'd2));
    send_item(make_item(kwm_pkg::CMD_END, 7, '0, '0));
    send_item(make_item(kwm_pkg::CMD_END, 7, '0, '0));
    send_item(make_item(kwm_pkg::CMD_RECORD, 7, 64'd1, 32'd1));
    send_item(make_item(kwm_pkg::CMD_RECORD, 0, 64'h5555_5555_5555_5555, 32'h5555_5555));
    send_item(make_item(kwm_pkg::CMD_RECORD, 2, '0, 32'h0000_ffff));
    send_item(make_item(kwm_pkg::CMD_RECORD, 4, 64'haaaa_aaaa_aaaa_aaaa, 32'haaaa_aaaa));
    send_item(make_item(kwm_pkg::CMD_RECORD, 5, 64'd1, 32'hffff_0000));
    send_item(make_item(kwm_pkg::CMD_RECORD, 6, '1, 32'd3));
    send_item(make_item(kwm_pkg::CMD_RECORD, 1, '0, 32'd4));
    settle();
    // shrink mid-merge: open run falls outside, so everything is ignored
    write_config(4'd2, 1'b0);
    send_item(make_item(kwm_pkg::CMD_RECORD, 0, 64'd2, 32'd6));
    send_item(make_item(kwm_pkg::CMD_RECORD, 3, 64'd2, 32'd7));
    settle();
    write_config(4'd4, 1'b0);
    send_item(make_item(kwm_pkg::CMD_RECORD, 3, 64'hffff_ffff_0000_0000, 32'd8));
    send_item(make_item(kwm_pkg::CMD_RECORD, 1, 64'd3, 32'd10));
    send_item(make_item(kwm_pkg::CMD_RECORD, 2, 64'd7, 32'd11));
    settle();
  endtask

  task automatic random_part();
    int                goal;
    int                budget;
    int                r;
    logic              cmd;
    kwm_pkg::in_item_t it;
    goal = book.consumed + RANDOM_ITEMS;
    while (book.consumed < goal) begin
      write_config(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
      budget = $urandom_range(10, 150);
      while (budget > 0 && book.pick_open_run() >= 0) begin
        idle_gap();
        if ($urandom_range(0, 9) < 8) begin
          it = make_item(kwm_pkg::CMD_RECORD, book.pick_open_run(), rand_key(), $urandom);
        end else begin
          // noise; an end is only sent where it is ignored, so runs stay alive
          r   = $urandom_range(0, kwm_pkg::MAX_LANES - 1);
          cmd = 1'($urandom_range(0, 1));
          if (cmd == kwm_pkg::CMD_END && book.is_open(r)) cmd = kwm_pkg::CMD_RECORD;
          it = make_item(cmd, r, rand_key(), $urandom);
        end
        send_item(it);
        budget--;
      end
      settle();
    end
  endtask

  // close the runs in widening groups so several done markers appear
  task automatic wind_down();
    int   ph;
    int   r;
    logic cmd;
    for (ph = 0; ph < 12 && !book.all_ended(); ph++) begin
      write_config(ph == 0 ? 4'd1 : ph == 1 ? 4'd3 : 4'd15, 1'($urandom_range(0, 1)));
      r = book.pick_open_run();
      while (r >= 0) begin
        idle_gap();
        cmd = ($urandom_range(0, 3) == 0) ? kwm_pkg::CMD_END : kwm_pkg::CMD_RECORD;
        send_item(make_item(cmd, r, rand_key(), $urandom));
        r = book.pick_open_run();
      end
      settle();
    end
  endtask

  initial begin
    book        = new();
    clk         = 1'b0;
    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    ready_left  = 0;
    cycle_count = 0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    directed_part();
    random_part();
    wind_down();
    settle();
    repeat (6) @(negedge clk);
    if (book.due_records.size() != 0) begin
      $display("%0t: %0d expected transactions never arrived", $time,
               book.due_records.size());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("[k_way_sorted_run_merge_core] OK");
    end else begin
      $display("[k_way_sorted_run_merge_core] ERROR");
    end
    $finish;
  end

endmodule

### k_way_sorted_run_merge_core.f
rtl/core/kwm_pkg.sv
rtl/core/kwm_heads.sv
rtl/core/kwm_select.sv
rtl/core/k_way_sorted_run_merge_core.sv
bench/tb_k_way_sorted_run_merge_core.sv
